// File: design/tgc_pkg.sv
// Shared types, constants and register codes for the touch gesture classifier.
package tgc_pkg;

    // Landscape screen size
    localparam int SCREEN_WIDTH  = 480;
    localparam int SCREEN_HEIGHT = 320;

    localparam int POS_W  = 9;
    localparam int RAW_W  = 12;
    localparam int TIME_W = 32;
    localparam int LONG_W = 16;

    localparam logic [POS_W-1:0] X_MAX = POS_W'(SCREEN_WIDTH - 1);
    localparam logic [POS_W-1:0] Y_MAX = POS_W'(SCREEN_HEIGHT - 1);

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_TOUCH_ENABLE    = 3'd0,
        REG_BUTTON_LEFT     = 3'd1,
        REG_BUTTON_TOP      = 3'd2,
        REG_BUTTON_WIDTH    = 3'd3,
        REG_BUTTON_HEIGHT   = 3'd4,
        REG_SWIPE_DIST      = 3'd5,
        REG_HOLD_MS         = 3'd6
    } reg_index_t;

    // Event codes
    typedef enum logic [2:0] {
        EV_TAP         = 3'd0,
        EV_LONG_HOLD   = 3'd1,
        EV_SWIPE_LEFT  = 3'd2,
        EV_SWIPE_RIGHT = 3'd3,
        EV_SWIPE_UP    = 3'd4,
        EV_SWIPE_DOWN  = 3'd5
    } event_code_t;

    // Register reset values
    localparam logic              RST_TOUCH_ENABLE    = 1'b1;
    localparam logic [POS_W-1:0]  RST_BUTTON_LEFT     = 9'd330;
    localparam logic [POS_W-1:0]  RST_BUTTON_TOP      = 9'd50;
    localparam logic [POS_W-1:0]  RST_BUTTON_WIDTH    = 9'd140;
    localparam logic [POS_W-1:0]  RST_BUTTON_HEIGHT   = 9'd100;
    localparam logic [POS_W-1:0]  RST_SWIPE_DIST      = 9'd50;
    localparam logic [LONG_W-1:0] RST_HOLD_MS         = 16'd500;

    typedef struct packed {
        logic              touch_enable;
        logic [POS_W-1:0]  button_left;
        logic [POS_W-1:0]  button_top;
        logic [POS_W-1:0]  button_width;
        logic [POS_W-1:0]  button_height;
        logic [POS_W-1:0]  swipe_dist;
        logic [LONG_W-1:0] hold_ms;
    } cfg_t;

    // Mapped poll held in the input stage
    typedef struct packed {
        logic              touch_down;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [TIME_W-1:0] now_ms;
    } poll_t;

    typedef struct packed {
        event_code_t      event_res;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic             on_button;
    } result_t;

    // Handshake between input stage and classifier
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctl_t;

endpackage

// File: design/tgc_if.sv
// Request channel interfaces for polls, events and configuration writes.
interface tgc_poll_if;
    logic        valid;
    logic        ready;
    logic        touch_down;
    logic [11:0] raw_x;
    logic [11:0] raw_y;
    logic [31:0] now_ms;

    modport source (output valid, touch_down, raw_x, raw_y, now_ms, input ready);
    modport sink (input valid, touch_down, raw_x, raw_y, now_ms, output ready);
endinterface

interface tgc_event_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [8:0] pos_x;
    logic [8:0] pos_y;
    logic       on_button;

    modport source (output valid, event_res, pos_x, pos_y, on_button, input ready);
    modport sink (input valid, event_res, pos_x, pos_y, on_button, output ready);
endinterface

interface tgc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: design/tgc_cfg_regs.sv
// Configuration register file written through the configuration channel.
module tgc_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    tgc_cfg_if.sink       cfg,
    output tgc_pkg::cfg_t regs
);

    tgc_pkg::cfg_t regs_reg;
    tgc_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // Decode write index
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                tgc_pkg::REG_TOUCH_ENABLE:    regs_next.touch_enable    = cfg.data[0];
                tgc_pkg::REG_BUTTON_LEFT:     regs_next.button_left     = cfg.data[8:0];
                tgc_pkg::REG_BUTTON_TOP:      regs_next.button_top      = cfg.data[8:0];
                tgc_pkg::REG_BUTTON_WIDTH:    regs_next.button_width    = cfg.data[8:0];
                tgc_pkg::REG_BUTTON_HEIGHT:   regs_next.button_height   = cfg.data[8:0];
                tgc_pkg::REG_SWIPE_DIST:      regs_next.swipe_dist      = cfg.data[8:0];
                tgc_pkg::REG_HOLD_MS:         regs_next.hold_ms         = cfg.data;
                default:                      regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.touch_enable    <= tgc_pkg::RST_TOUCH_ENABLE;
            regs_reg.button_left     <= tgc_pkg::RST_BUTTON_LEFT;
            regs_reg.button_top      <= tgc_pkg::RST_BUTTON_TOP;
            regs_reg.button_width    <= tgc_pkg::RST_BUTTON_WIDTH;
            regs_reg.button_height   <= tgc_pkg::RST_BUTTON_HEIGHT;
            regs_reg.swipe_dist      <= tgc_pkg::RST_SWIPE_DIST;
            regs_reg.hold_ms         <= tgc_pkg::RST_HOLD_MS;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// File: design/tgc_poll_stage.sv
// Input register for polls and portrait-to-landscape coordinate mapping.
module tgc_poll_stage (
    input  logic                clk,
    input  logic                rst_n,
    tgc_poll_if.sink            poll,
    input  logic                advance,
    output logic                valid,
    output tgc_pkg::poll_t      mapped
);

    localparam logic [12:0] WIDTH13  = 13'(tgc_pkg::SCREEN_WIDTH);
    localparam logic [12:0] HEIGHT13 = 13'(tgc_pkg::SCREEN_HEIGHT);

    logic        valid_reg;
    logic        valid_next;
    logic        down_reg;
    logic [11:0] raw_x_reg;
    logic [11:0] raw_y_reg;
    logic [31:0] now_reg;
    logic        accept;
    logic [12:0] x_wide;
    logic [12:0] y_wide;

    // Take a new request when empty or when the held poll moves on
    assign poll.ready = !valid_reg || advance;
    assign accept     = poll.valid && poll.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload of the accepted request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            down_reg  <= poll.touch_down;
            raw_x_reg <= poll.raw_x;
            raw_y_reg <= poll.raw_y;
            now_reg   <= poll.now_ms;
        end
    end

    // x = raw_y*(W-1)/W clamped: zero at zero, W-1 at or beyond W, else raw_y-1
    always_comb
    begin
        if (raw_y_reg == 12'd0)
        begin
            x_wide = 13'd0;
        end
        else if ({1'b0, raw_y_reg} >= WIDTH13)
        begin
            x_wide = WIDTH13 - 13'd1;
        end
        else
        begin
            x_wide = {1'b0, raw_y_reg} - 13'd1;
        end
    end

    // y = (H-raw_x)*(H-1)/H: zero at or beyond H, else H-1-raw_x
    always_comb
    begin
        if ({1'b0, raw_x_reg} >= HEIGHT13)
        begin
            y_wide = 13'd0;
        end
        else
        begin
            y_wide = HEIGHT13 - 13'd1 - {1'b0, raw_x_reg};
        end
    end

    assign valid             = valid_reg;
    assign mapped.touch_down = down_reg;
    assign mapped.x          = x_wide[8:0];
    assign mapped.y          = y_wide[8:0];
    assign mapped.now_ms     = now_reg;

endmodule

// File: design/tgc_classify.sv
// Touch tracking state, button hit test and release classification.
module tgc_classify (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tgc_pkg::cfg_t        regs,
    input  tgc_pkg::poll_t       poll,
    input  logic                 poll_valid,
    input  logic                 out_free,
    output tgc_pkg::stage_ctl_t  ctl,
    output logic                 res_valid,
    output tgc_pkg::result_t     res
);

    logic        active_reg;
    logic        active_next;
    logic [8:0]  start_x_reg;
    logic [8:0]  start_y_reg;
    logic [31:0] start_time_reg;
    logic [8:0]  end_x_reg;
    logic [8:0]  end_y_reg;

    logic        advance;
    logic        emit;
    logic        in_button;
    logic [9:0]  right_edge;
    logic [9:0]  bottom_edge;
    logic [9:0]  dx;
    logic [9:0]  dy;
    logic [9:0]  adx_wide;
    logic [9:0]  ady_wide;
    logic [8:0]  adx;
    logic [8:0]  ady;
    logic        dx_pos;
    logic        dy_pos;
    logic        swipe;
    logic [31:0] duration;
    logic        held_long;
    logic        press_start;
    logic        release_now;
    tgc_pkg::event_code_t gesture;

    // Button hit test, edges inclusive
    assign right_edge  = {1'b0, regs.button_left} + {1'b0, regs.button_width};
    assign bottom_edge = {1'b0, regs.button_top} + {1'b0, regs.button_height};
    assign in_button   = (poll.x >= regs.button_left) && ({1'b0, poll.x} <= right_edge)
                      && (poll.y >= regs.button_top) && ({1'b0, poll.y} <= bottom_edge);

    // Deltas from start to last pressed point
    assign dx       = {1'b0, end_x_reg} - {1'b0, start_x_reg};
    assign dy       = {1'b0, end_y_reg} - {1'b0, start_y_reg};
    assign adx_wide = dx[9] ? (10'd0 - dx) : dx;
    assign ady_wide = dy[9] ? (10'd0 - dy) : dy;
    assign adx      = adx_wide[8:0];
    assign ady      = ady_wide[8:0];
    assign dx_pos   = !dx[9] && (dx != 10'd0);
    assign dy_pos   = !dy[9] && (dy != 10'd0);
    assign swipe    = (adx > regs.swipe_dist) || (ady > regs.swipe_dist);

    // Wrapping press duration
    assign duration  = poll.now_ms - start_time_reg;
    assign held_long = duration > {16'd0, regs.hold_ms};

    always_comb
    begin
        if (swipe)
        begin
            if (adx > ady)
            begin
                gesture = dx_pos ? tgc_pkg::EV_SWIPE_RIGHT : tgc_pkg::EV_SWIPE_LEFT;
            end
            else
            begin
                gesture = dy_pos ? tgc_pkg::EV_SWIPE_DOWN : tgc_pkg::EV_SWIPE_UP;
            end
        end
        else if (held_long)
        begin
            gesture = tgc_pkg::EV_LONG_HOLD;
        end
        else
        begin
            gesture = tgc_pkg::EV_TAP;
        end
    end

    assign press_start = regs.touch_enable && poll.touch_down && !active_reg;
    assign release_now = regs.touch_enable && !poll.touch_down && active_reg;

    // Pick the result for this poll
    always_comb
    begin
        emit          = 1'b0;
        res.event_res = tgc_pkg::EV_TAP;
        res.pos_x     = end_x_reg;
        res.pos_y     = end_y_reg;
        res.on_button = 1'b0;
        if (press_start && in_button)
        begin
            emit          = 1'b1;
            res.pos_x     = poll.x;
            res.pos_y     = poll.y;
            res.on_button = 1'b1;
        end
        else if (release_now)
        begin
            emit          = 1'b1;
            res.event_res = gesture;
        end
    end

    // Advance unless a result has nowhere to go
    assign advance     = poll_valid && (!emit || out_free);
    assign ctl.valid   = poll_valid;
    assign ctl.advance = advance;
    assign res_valid   = poll_valid && emit;

    always_comb
    begin
        active_next = active_reg;
        if (advance && press_start)
        begin
            active_next = 1'b1;
        end
        else if (advance && release_now)
        begin
            active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            start_time_reg <= '0;
            end_x_reg      <= '0;
            end_y_reg      <= '0;
        end
        else
        begin
            active_reg <= active_next;
            // Latch start point and time on first pressed poll
            if (advance && press_start)
            begin
                start_x_reg    <= poll.x;
                start_y_reg    <= poll.y;
                start_time_reg <= poll.now_ms;
            end
            // Track last pressed point
            if (advance && regs.touch_enable && poll.touch_down)
            begin
                end_x_reg <= poll.x;
                end_y_reg <= poll.y;
            end
        end
    end

endmodule

// File: design/touch_gesture_classifier.sv
// Touch gesture classifier top level: config registers, poll stage, classifier, event register.
// One touch poll is taken per clock cycle unless the input register stalls. A poll moves
// from the input register through combinational coordinate mapping and classification
// into the event register, from which its event, if any, is offered. The input register
// stalls only when its poll produces an event while the event register still holds one
// not yet taken.
// Button taps are reported at the first pressed poll of a touch; tap, long press and swipe
// events at the first released poll, at the last pressed point. With touch_enable cleared,
// polls are consumed and dropped. Configuration writes are taken every cycle and belong
// in idle periods only.
module touch_gesture_classifier (
    input  logic         clk,
    input  logic         rst_n,
    tgc_cfg_if.sink      cfg,
    tgc_poll_if.sink     poll,
    tgc_event_if.source  evt
);

    tgc_pkg::cfg_t       regs;
    tgc_pkg::poll_t      mapped;
    tgc_pkg::stage_ctl_t ctl;
    tgc_pkg::result_t    res;
    tgc_pkg::result_t    evt_data_reg;
    logic                stage_valid;
    logic                res_valid;
    logic                out_free;
    logic                evt_valid_reg;
    logic                evt_valid_next;
    logic                load;

    tgc_cfg_regs u_cfg_regs (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg),
        .regs (regs)
    );

    tgc_poll_stage u_poll_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .poll   (poll),
        .advance(ctl.advance),
        .valid  (stage_valid),
        .mapped (mapped)
    );

    tgc_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .regs      (regs),
        .poll      (mapped),
        .poll_valid(stage_valid),
        .out_free  (out_free),
        .ctl       (ctl),
        .res_valid (res_valid),
        .res       (res)
    );

    // Event register
    assign out_free = !evt_valid_reg || evt.ready;
    assign load     = res_valid && ctl.advance;

    always_comb
    begin
        evt_valid_next = evt_valid_reg;
        if (load)
        begin
            evt_valid_next = 1'b1;
        end
        else if (evt.ready)
        begin
            evt_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
        end
        else
        begin
            evt_valid_reg <= evt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            evt_data_reg <= res;
        end
    end

    assign evt.valid     = evt_valid_reg;
    assign evt.event_res = evt_data_reg.event_res;
    assign evt.pos_x     = evt_data_reg.pos_x;
    assign evt.pos_y     = evt_data_reg.pos_y;
    assign evt.on_button = evt_data_reg.on_button;

    // Button hit is always reported as a tap
    a_button_is_tap: assert property (@(posedge clk) disable iff (!rst_n)
        evt.valid && evt.on_button |-> evt.event_res == tgc_pkg::EV_TAP)
        else $error("button event with non-tap code");

    // Reported point lies on the screen
    a_pos_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        evt.valid |-> (evt.pos_x <= tgc_pkg::X_MAX) && (evt.pos_y <= tgc_pkg::Y_MAX))
        else $error("event position off screen");

    // A stalled poll blocks new requests
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.valid && !ctl.advance |-> !poll.ready)
        else $error("poll accepted while stage stalled");

    // Event register only loads when free
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> out_free)
        else $error("event register overwritten");

endmodule
